[sv/cbts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cbts_pkg;

  localparam int CLK_W     = 31;
  localparam int RATE_W    = 26;
  localparam int PRESC_W   = 10;
  localparam int SEG1_W    = 4;
  localparam int SEG2_W    = 3;
  localparam int DIV_STEPS = CLK_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [CLK_W-1:0]  CLK_RESET  = 31'd54000000;
  localparam logic [CLK_W-1:0]  MIN_QUANTA = 31'd5;
  localparam logic [CLK_W-1:0]  MAX_QUANTA = 31'd16;
  localparam logic [SEG1_W-1:0] SEG2_CAP   = 4'd8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_CLK,
    S_DIV_RATE,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic             start;
    logic [CLK_W-1:0] dividend;
    logic [CLK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CLK_W-1:0] quotient;
    logic [CLK_W-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic               found;
    logic [PRESC_W-1:0] prescaler_field;
    logic [SEG1_W-1:0]  seg1_field;
    logic [SEG2_W-1:0]  seg2_field;
    logic [RATE_W-1:0]  achieved_rate;
  } timing_t;

endpackage
`default_nettype wire

[sv/cbts_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface cbts_rate_if import cbts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate_bps;

  modport source (output valid, output rate_bps, input ready);
  modport sink (input valid, input rate_bps, output ready);
endinterface

interface cbts_timing_if import cbts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [PRESC_W-1:0] prescaler_field;
  logic [SEG1_W-1:0]  seg1_field;
  logic [SEG2_W-1:0]  seg2_field;
  logic [RATE_W-1:0]  achieved_rate;

  modport source (output valid, output found, output prescaler_field, output seg1_field,
                  output seg2_field, output achieved_rate, input ready);
  modport sink (input valid, input found, input prescaler_field, input seg1_field,
                input seg2_field, input achieved_rate, output ready);
endinterface
`default_nettype wire

[sv/can_bit_timing_search.sv]
`timescale 1ns / 1ps
// CAN bit timing search.
// rate_req (sink): one request carries rate_bps. timing_rsp (source): one
// result per request with found, prescaler_field, seg1_field, seg2_field and
// achieved_rate; on failure all fields are zero.
// cfg_we/cfg_data write clock_hz (reset value 54 MHz); write only when idle.
// Prescalers 1 .. PRESCALER_LIMIT-1 are tried in order; each trial runs two
// 31-step divisions (clock/prescaler, then by the rate) on one shared serial
// divider, and stops at the first prescaler that fits. A zero rate skips
// the divisions. One request is in flight at a time: rate_req.ready is
// high only while the sequencer is idle.
// The result sits in an output register; when the receiver stalls the
// sequencer holds it until the register frees, then takes the next request.
// Synchronous reset clears the handshake state and restores clock_hz.
`default_nettype none
module can_bit_timing_search import cbts_pkg::*; #(
  parameter int PRESCALER_LIMIT = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst,
  cbts_rate_if.sink           rate_req,
  cbts_timing_if.source       timing_rsp,
  input  wire logic           cfg_we,
  input  wire logic [CLK_W-1:0] cfg_data
);

  logic [CLK_W-1:0] clock_hz;
  logic             res_valid;
  logic             res_take;
  timing_t          res;
  timing_t          out_reg;
  logic             out_valid;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLK_RESET;
    end else if (cfg_we) begin
      clock_hz <= cfg_data;
    end
  end

  assign res_take = res_valid && (!out_valid || timing_rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (timing_rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_reg <= res;
    end
  end

  assign timing_rsp.valid           = out_valid;
  assign timing_rsp.found           = out_reg.found;
  assign timing_rsp.prescaler_field = out_reg.prescaler_field;
  assign timing_rsp.seg1_field      = out_reg.seg1_field;
  assign timing_rsp.seg2_field      = out_reg.seg2_field;
  assign timing_rsp.achieved_rate   = out_reg.achieved_rate;

  cbts_seq #(
    .PRESCALER_LIMIT(PRESCALER_LIMIT)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .clock_hz  (clock_hz),
    .req_valid (rate_req.valid),
    .req_rate  (rate_req.rate_bps),
    .req_ready (rate_req.ready),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  cbts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule
`default_nettype wire

[sv/cbts_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle
module cbts_div import cbts_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [CLK_W-1:0] quo;
  logic [CLK_W-1:0] rem;
  logic [CLK_W-1:0] divisor;
  logic [CLK_W:0]   trial;
  logic [CLK_W:0]   diff;
  logic             ge;

  assign trial = {rem, quo[CLK_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[CLK_W-1:0] : trial[CLK_W-1:0];
      quo <= {quo[CLK_W-2:0], ge};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

[sv/cbts_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
module cbts_seq import cbts_pkg::*; #(
  parameter int PRESCALER_LIMIT = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CLK_W-1:0]  clock_hz,
  input  wire logic              req_valid,
  input  wire logic [RATE_W-1:0] req_rate,
  output logic                   req_ready,
  output logic                   res_valid,
  input  wire logic              res_take,
  output timing_t                res,
  output div_req_t               div_req,
  input  wire div_rsp_t          div_rsp
);

  localparam int BRP_W = $clog2(PRESCALER_LIMIT);

  seq_state_t        state, state_next;
  logic [BRP_W-1:0]  brp;
  logic [RATE_W-1:0] rate;
  logic              accept;
  logic              tq_ok;
  logic              last_brp;
  logic [3:0]        tqm1;
  logic [SEG1_W-1:0] seg1, seg2, seg1_c, seg2_c, seg1_m1, seg2_m1;

  assign accept   = req_valid && req_ready;
  assign last_brp = brp == BRP_W'(PRESCALER_LIMIT - 1);
  assign tq_ok    = div_rsp.quotient >= MIN_QUANTA && div_rsp.quotient <= MAX_QUANTA &&
                    div_rsp.remainder < div_rsp.quotient;

  always_comb begin
    tqm1 = div_rsp.quotient[3:0] - 4'd1;
    seg2 = {1'b0, tqm1[3:1]};
    seg1 = seg2 + {3'b0, tqm1[0]};
    if (seg2 > SEG2_CAP) begin
      seg1_c = seg1 + seg2 - SEG2_CAP;
      seg2_c = SEG2_CAP;
    end else begin
      seg1_c = seg1;
      seg2_c = seg2;
    end
    seg1_m1 = seg1_c - 4'd1;
    seg2_m1 = seg2_c - 4'd1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req_rate == '0) ? S_DONE : S_DIV_CLK;
        end
      end
      S_DIV_CLK: begin
        if (div_rsp.done) begin
          state_next = S_DIV_RATE;
        end
      end
      S_DIV_RATE: begin
        if (div_rsp.done) begin
          state_next = (tq_ok || last_brp) ? S_DONE : S_DIV_CLK;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready        = state == S_IDLE;
    res_valid        = state == S_DONE;
    div_req.start    = 1'b0;
    div_req.dividend = clock_hz;
    div_req.divisor  = CLK_W'(1);
    unique case (state)
      S_IDLE: begin
        div_req.start = accept && req_rate != '0;
      end
      S_DIV_CLK: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = div_rsp.quotient;
        div_req.divisor  = CLK_W'(rate);
      end
      S_DIV_RATE: begin
        div_req.start   = div_rsp.done && !tq_ok && !last_brp;
        div_req.divisor = CLK_W'(brp) + CLK_W'(1);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      rate <= req_rate;
      brp  <= BRP_W'(1);
      res  <= '0;
    end else if (state == S_DIV_RATE && div_rsp.done) begin
      if (tq_ok) begin
        res.found           <= 1'b1;
        res.prescaler_field <= PRESC_W'(brp - BRP_W'(1));
        res.seg1_field      <= seg1_m1;
        res.seg2_field      <= seg2_m1[SEG2_W-1:0];
        res.achieved_rate   <= rate;
      end else begin
        brp <= brp + BRP_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[sim/tb_can_bit_timing_search.sv]
`timescale 1ns / 1ps
module tb_can_bit_timing_search import cbts_pkg::*; ();

  localparam int PRESC_LIMIT = 1024;
  localparam int STALL_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;
  localparam logic [CLK_W-1:0] CLK_MAX = 31'h7FFFFFFF;
  localparam logic [RATE_W-1:0] RATE_MAX = 26'h3FFFFFF;
  localparam timing_t NO_TIMING = '0;

  typedef struct packed {
    logic [CLK_W-1:0]  clk_hz;
    logic [RATE_W-1:0] rate;
    logic              typed;
    timing_t           want;
  } probe_t;

  localparam int N_PROBES = 16;
  localparam probe_t PROBES [N_PROBES] = '{
    '{CLK_RESET, 26'd0, 1'b1, NO_TIMING},
    '{CLK_RESET, 26'd10800000, 1'b0, NO_TIMING},
    '{CLK_RESET, 26'd3375000, 1'b0, NO_TIMING},
    '{CLK_RESET, 26'd6750000, 1'b0, NO_TIMING},
    '{CLK_RESET, 26'd1000000, 1'b0, NO_TIMING},
    '{CLK_RESET, 26'd500000, 1'b0, NO_TIMING},
    '{CLK_RESET, 26'd250000, 1'b0, NO_TIMING},
    '{CLK_RESET, 26'd125000, 1'b0, NO_TIMING},
    '{CLK_RESET, 26'd10000, 1'b0, NO_TIMING},
    '{CLK_RESET, RATE_MAX, 1'b1, NO_TIMING},
    '{31'd0, 26'd500000, 1'b1, NO_TIMING},
    '{31'd5, 26'd1, 1'b0, NO_TIMING},
    '{31'd16, 26'd1, 1'b0, NO_TIMING},
    '{31'd1, 26'd1, 1'b1, NO_TIMING},
    '{CLK_MAX, RATE_MAX, 1'b0, NO_TIMING},
    '{CLK_MAX, 26'd33554431, 1'b0, NO_TIMING}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CLK_W-1:0] cfg_data;

  cbts_rate_if rate_req();
  cbts_timing_if timing_rsp();

  can_bit_timing_search #(.PRESCALER_LIMIT(PRESC_LIMIT)) dut (
    .clk(clk),
    .rst(rst),
    .rate_req(rate_req),
    .timing_rsp(timing_rsp),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [CLK_W-1:0] clock_cfg = CLK_RESET;
  timing_t pending_timing [$];
  int fail_count = 0;
  bit req_burst = 1'b0;
  bit rsp_burst = 1'b0;
  int unsigned rsp_hold = 0;
  int unsigned idle_cycles = 0;
  timing_t got_timing;
  timing_t want_timing;

  function automatic timing_t solve_timing(input logic [CLK_W-1:0] clk_hz,
                                           input logic [RATE_W-1:0] rate);
    timing_t t;
    int unsigned c, r, brp, tq, s1, s2;
    bit hit;
    t = '0;
    hit = 1'b0;
    tq = 0;
    c = 32'(clk_hz);
    r = 32'(rate);
    if (r == 0) return t;
    for (brp = 1; brp < PRESC_LIMIT; brp++) begin
      tq = c / brp / r;
      if (tq >= 32'(MIN_QUANTA) && tq <= 32'(MAX_QUANTA) && c / brp / tq == r) begin
        hit = 1'b1;
        break;
      end
    end
    if (!hit) return t;
    s1 = (tq - 1) / 2;
    s2 = s1;
    if (tq - (1 + s1 + s2) == 1) s1++;
    if (s2 > 32'(SEG2_CAP)) begin
      s1 += s2 - 32'(SEG2_CAP);
      s2 = 32'(SEG2_CAP);
    end
    t.found = 1'b1;
    t.prescaler_field = PRESC_W'(brp - 1);
    t.seg1_field = SEG1_W'(s1 - 1);
    t.seg2_field = SEG2_W'(s2 - 1);
    t.achieved_rate = rate;
    return t;
  endfunction

  // rate built from a chosen prescaler and quanta count; rate >= 17 makes
  // the search stop no later than that prescaler
  function automatic logic [RATE_W-1:0] pick_rate(input logic [CLK_W-1:0] clk_hz);
    int unsigned c, tq, lo, hi, brp;
    c = 32'(clk_hz);
    tq = $urandom_range(5, 16);
    lo = ((c / tq) >> RATE_W) + 1;
    hi = c / (tq * 17);
    if (hi > PRESC_LIMIT - 1) hi = PRESC_LIMIT - 1;
    if (hi < lo) hi = lo;
    if ($urandom_range(0, 19) == 0) brp = $urandom_range(lo, (hi > 511) ? 511 : hi);
    else brp = $urandom_range(lo, (hi > lo + 7) ? lo + 7 : hi);
    return RATE_W'(c / brp / tq);
  endfunction

  function automatic logic [CLK_W-1:0] pick_clock();
    logic [CLK_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = CLK_RESET;
      1: v = CLK_MAX;
      2: v = CLK_W'($urandom_range(1000, 100000));
      default: begin
        v = CLK_W'($urandom >> 1);
        if (v < 1000) v = 31'd1000;
      end
    endcase
    return v;
  endfunction

  function automatic string timing_str(input timing_t t);
    return $sformatf("found=%0d presc=%0d seg1=%0d seg2=%0d rate=%0d",
                     t.found, t.prescaler_field, t.seg1_field, t.seg2_field,
                     t.achieved_rate);
  endfunction

  task automatic note_failure(input string what, input timing_t want, input timing_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%s: expected %s, got %s", what, timing_str(want), timing_str(got));
  endtask

  task automatic send_rate(input logic [RATE_W-1:0] rate, input logic typed,
                           input timing_t want);
    int unsigned gap;
    gap = req_burst ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 11) == 0) req_burst = !req_burst;
    if (gap != 0) begin
      rate_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rate_req.valid <= 1'b1;
    rate_req.rate_bps <= rate;
    @(posedge clk);
    while (!rate_req.ready) @(posedge clk);
    pending_timing.push_back(typed ? want : solve_timing(clock_cfg, rate));
  endtask

  // only while idle
  task automatic write_clock(input logic [CLK_W-1:0] value);
    rate_req.valid <= 1'b0;
    while (pending_timing.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    clock_cfg = value;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      timing_rsp.ready <= 1'b0;
      rsp_hold = 0;
    end else if (timing_rsp.valid && timing_rsp.ready) begin
      got_timing = {timing_rsp.found, timing_rsp.prescaler_field, timing_rsp.seg1_field,
                    timing_rsp.seg2_field, timing_rsp.achieved_rate};
      if (pending_timing.size() == 0) begin
        note_failure("unexpected timing", NO_TIMING, got_timing);
      end else begin
        want_timing = pending_timing.pop_front();
        if (got_timing.found !== want_timing.found ||
            got_timing.prescaler_field !== want_timing.prescaler_field ||
            got_timing.seg1_field !== want_timing.seg1_field ||
            got_timing.seg2_field !== want_timing.seg2_field ||
            got_timing.achieved_rate !== want_timing.achieved_rate)
          note_failure("timing mismatch", want_timing, got_timing);
      end
      if ($urandom_range(0, 11) == 0) rsp_burst = !rsp_burst;
      rsp_hold = rsp_burst ? 0 : $urandom_range(0, 11);
      if (rsp_hold != 0) begin
        timing_rsp.ready <= 1'b0;
        rsp_hold--;
      end
    end else if (!timing_rsp.ready) begin
      if (rsp_hold == 0) timing_rsp.ready <= 1'b1;
      else rsp_hold--;
    end
  end

  always @(posedge clk) begin
    if (rst || (rate_req.valid && rate_req.ready) || (timing_rsp.valid && timing_rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_can_bit_timing_search failed");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    rate_req.valid <= 1'b0;
    rate_req.rate_bps <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_PROBES; i++) begin
      if (PROBES[i].clk_hz != clock_cfg) write_clock(PROBES[i].clk_hz);
      send_rate(PROBES[i].rate, PROBES[i].typed, PROBES[i].want);
    end

    // mostly exact rates, a few arbitrary ones
    for (int ph = 0; ph < 5; ph++) begin
      write_clock(pick_clock());
      for (int n = 0; n < 20; n++) begin
        if ($urandom_range(0, 24) == 0)
          send_rate(RATE_W'($urandom >> $urandom_range(6, 31)), 1'b0, NO_TIMING);
        else
          send_rate(pick_rate(clock_cfg), 1'b0, NO_TIMING);
      end
    end

    rate_req.valid <= 1'b0;
    while (pending_timing.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_can_bit_timing_search passed");
    end else begin
      $display("tb_can_bit_timing_search failed");
    end
    $finish;
  end

endmodule
